// ===== hdl/node_registry_interval_scheduler_macros.svh =====
// assertion macros for the node registry and interval scheduler
`ifndef NODE_REGISTRY_INTERVAL_SCHEDULER_MACROS_SVH
`define NODE_REGISTRY_INTERVAL_SCHEDULER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define NRIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define NRIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nris_pkg.sv =====
// types and codes shared by the node registry and interval scheduler
package nris_pkg;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] KIND_NODE     = 2'd0;
    localparam logic [1:0] KIND_ADDED    = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;

    localparam int MAX_RESULTS = 64;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] node_address;
        logic [31:0] interval;
        logic [7:0]  handler_id;
        logic        scope_all;
        logic [31:0] current_time;
    } request_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [2:0] node_id;
        logic       status;
        logic [7:0] fired_handler;
        logic       dispatch_all;
        logic [3:0] node_count;
        logic       last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic clr_idx;    // reset scan index
        logic inc_idx;    // advance scan index
        logic clr_h;      // reset handler index
        logic inc_h;      // advance handler index
        logic node_app;   // append node address
        logic slot_join;  // append handler to matched slot
        logic slot_new;   // open new slot
        logic resched;    // reschedule current slot
        logic emit_node;
        logic emit_add;
        logic emit_disp;
        logic mark_last;  // emit flagged as final
        logic tick_any;   // mark that a dispatch went out
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       node_end;    // scan index reached node count
        logic       node_hit;
        logic       node_full;
        logic       slot_end;    // scan index reached slot count
        logic       slot_hit;
        logic       slot_full;
        logic       slot_due;
        logic       h_end;       // handler index reached count
        logic       h_full;      // matched slot has no room
        logic       h_last;      // current handler is the slot's last
        logic       later_due;   // another due slot with handlers follows
        logic       cap_ok;
        logic       any_sent;
    } stat_t;

endpackage

// ===== hdl/node_registry_interval_scheduler.sv =====
// top level of the node registry and interval scheduler
//
//  channel  | handshake          | payload
//  request  | start / busy       | req     (nris_pkg::request_t)
//  result   | done strobe        | result  (nris_pkg::result_t)
//
// lookup: one node table entry compared per cycle in the scan
// add: one slot compared per cycle
// tick: scans the slots in use and, for each due slot, reads its handlers
// from one ram port one per cycle; an unused request type returns to idle
// without a result
// reset empties the slot table and leaves only the own node; no clearing pass
// results are shown for one cycle each; the receiver cannot stall
module node_registry_interval_scheduler
#(
    parameter int NODE_SLOTS        = 8,
    parameter int HANDLERS_PER_SLOT = 8,
    parameter int INTERVAL_SLOTS    = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  nris_pkg::request_t req,
    output logic               done,
    output nris_pkg::result_t  result
);

    nris_pkg::ctrl_t ct;
    nris_pkg::stat_t st;

    nris_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .ct    (ct)
    );

    nris_datapath #(
        .NODE_SLOTS        (NODE_SLOTS),
        .HANDLERS_PER_SLOT (HANDLERS_PER_SLOT),
        .INTERVAL_SLOTS    (INTERVAL_SLOTS)
    ) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .ct     (ct),
        .st     (st),
        .done   (done),
        .result (result)
    );

endmodule

// ===== hdl/nris_ctrl.sv =====
// controller state machine for the node registry and interval scheduler
`include "node_registry_interval_scheduler_macros.svh"

module nris_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  nris_pkg::stat_t st,
    output nris_pkg::ctrl_t ct
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_NODE = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_SLOT = 3'd4;
    localparam logic [2:0] S_DISP = 3'd5;

    logic [2:0] state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ct = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ct.load = 1'b1;
                    ct.clr_idx = 1'b1;
                    ct.clr_h = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (st.req_type)
                    nris_pkg::REQ_LOOKUP: state_next = S_NODE;
                    nris_pkg::REQ_ADD:    state_next = S_ADD;
                    nris_pkg::REQ_TICK:   state_next = S_SLOT;
                    default:              state_next = S_IDLE;
                endcase
            end
            S_NODE:
            begin
                if (st.node_hit)
                begin
                    ct.emit_node = 1'b1;
                    state_next = S_IDLE;
                end
                else if (st.node_end)
                begin
                    ct.node_app = !st.node_full;
                    ct.emit_node = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ct.inc_idx = 1'b1;
                end
            end
            S_ADD:
            begin
                if (st.slot_hit)
                begin
                    ct.slot_join = !st.h_full;
                    ct.emit_add = 1'b1;
                    state_next = S_IDLE;
                end
                else if (st.slot_end)
                begin
                    ct.slot_new = !st.slot_full;
                    ct.emit_add = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ct.inc_idx = 1'b1;
                end
            end
            S_SLOT:
            begin
                ct.clr_h = 1'b1;
                if (st.slot_end)
                begin
                    state_next = S_IDLE;
                end
                else if (st.slot_due && !st.h_end)
                begin
                    state_next = S_DISP;
                end
                else
                begin
                    ct.resched = st.slot_due;
                    ct.inc_idx = 1'b1;
                end
            end
            S_DISP:
            begin
                ct.emit_disp = st.cap_ok;
                ct.tick_any = st.cap_ok;
                ct.mark_last = st.h_last && !st.later_due;
                ct.inc_h = 1'b1;
                if (st.h_last)
                begin
                    ct.resched = 1'b1;
                    ct.inc_idx = 1'b1;
                    ct.clr_h = 1'b1;
                    state_next = S_SLOT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `NRIS_ASSERT(a_one_emit, $onehot0({ct.emit_node, ct.emit_add, ct.emit_disp}), "two emits")
    `NRIS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
    `NRIS_ASSERT(a_idle_quiet, !(state_reg == S_IDLE) || !(ct.inc_idx || ct.emit_disp),
        "idle controller issues work")

endmodule

// ===== hdl/nris_datapath.sv =====
// tables, scan indices and result register of the scheduler
`include "node_registry_interval_scheduler_macros.svh"

module nris_datapath
#(
    parameter int NODE_SLOTS        = 8,
    parameter int HANDLERS_PER_SLOT = 8,
    parameter int INTERVAL_SLOTS    = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  nris_pkg::request_t req,
    input  nris_pkg::ctrl_t    ct,
    output nris_pkg::stat_t    st,
    output logic               done,
    output nris_pkg::result_t  result
);

    localparam int NW = $clog2(NODE_SLOTS + 1);
    localparam int NI = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int SW = $clog2(INTERVAL_SLOTS + 1);
    localparam int SI = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
    localparam int HW = $clog2(HANDLERS_PER_SLOT + 1);
    localparam int HI = (HANDLERS_PER_SLOT > 1) ? $clog2(HANDLERS_PER_SLOT) : 1;
    localparam int IW = (NW > SW) ? NW : SW;
    localparam int KW = $clog2(nris_pkg::MAX_RESULTS + 1);
    localparam int HD = 1 << (SI + HI);

    nris_pkg::request_t req_reg;
    logic [63:0] node_tab [NODE_SLOTS];
    logic [NW-1:0] nodes_reg;
    logic [31:0] period_tab [INTERVAL_SLOTS];
    logic [31:0] due_tab [INTERVAL_SLOTS];
    logic [HW-1:0] hcnt_tab [INTERVAL_SLOTS];
    logic [SW-1:0] slots_reg;
    logic [IW-1:0] idx_reg;
    logic [HW-1:0] h_reg;
    logic [KW-1:0] sent_reg;
    logic [SI-1:0] si;
    logic [NI-1:0] ni;
    logic [SI+HI-1:0] rd_addr, wr_addr;
    logic [8:0] wr_data, rd_data;
    logic wr_en;
    nris_pkg::result_t result_reg, result_next;
    logic done_reg;
    logic [INTERVAL_SLOTS-1:0] due_vec;
    logic later;

    assign si = idx_reg[SI-1:0];
    assign ni = idx_reg[NI-1:0];

    // due flags for slots beyond the current one
    always_comb
    begin
        for (int s = 0; s < INTERVAL_SLOTS; s++)
        begin
            due_vec[s] = (SW'(s) < slots_reg) && (req_reg.current_time >= due_tab[s])
                && (hcnt_tab[s] != '0) && (IW'(s) > idx_reg);
        end
        later = |due_vec;
    end

    // status towards the controller
    always_comb
    begin
        st.req_type  = req_reg.req_type;
        st.node_end  = (idx_reg >= IW'(nodes_reg));
        st.node_hit  = !st.node_end && (node_tab[ni] == req_reg.node_address);
        st.node_full = (nodes_reg == NW'(NODE_SLOTS));
        st.slot_end  = (idx_reg >= IW'(slots_reg));
        st.slot_hit  = !st.slot_end && (period_tab[si] == req_reg.interval);
        st.slot_full = (slots_reg == SW'(INTERVAL_SLOTS));
        st.slot_due  = (req_reg.current_time >= due_tab[si]);
        st.h_end     = (h_reg >= hcnt_tab[si]);
        st.h_full    = (hcnt_tab[si] == HW'(HANDLERS_PER_SLOT));
        st.h_last    = (h_reg + HW'(1) >= hcnt_tab[si]);
        st.later_due = later;
        st.cap_ok    = (sent_reg < KW'(nris_pkg::MAX_RESULTS));
        st.any_sent  = (sent_reg != '0);
    end

    // handler store, read at the next handler of the scanned slot
    always_comb
    begin
        wr_en = ct.slot_join || ct.slot_new;
        wr_addr = {si, ct.slot_new ? HI'(0) : hcnt_tab[si][HI-1:0]};
        wr_data = {req_reg.scope_all, req_reg.handler_id};
        rd_addr = {si, ct.inc_h ? h_reg[HI-1:0] + HI'(1) : h_reg[HI-1:0]};
        if (ct.clr_h)
        begin
            rd_addr = {ct.inc_idx ? si + SI'(1) : si, HI'(0)};
        end
    end

    nris_ram #(.WIDTH(9), .DEPTH(HD)) u_hram
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // request capture, counters and indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= NW'(1);
            slots_reg <= '0;
            idx_reg   <= '0;
            h_reg     <= '0;
            sent_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ct.emit_node || ct.emit_add || ct.emit_disp;
            if (ct.load)
            begin
                sent_reg <= '0;
            end
            else if (ct.tick_any)
            begin
                sent_reg <= sent_reg + KW'(1);
            end
            if (ct.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (ct.inc_idx)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (ct.clr_h)
            begin
                h_reg <= '0;
            end
            else if (ct.inc_h)
            begin
                h_reg <= h_reg + HW'(1);
            end
            if (ct.node_app)
            begin
                nodes_reg <= nodes_reg + NW'(1);
            end
            if (ct.slot_new)
            begin
                slots_reg <= slots_reg + SW'(1);
            end
        end
    end

    // node table, cleared at reset so entry 0 holds the own address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NODE_SLOTS; n++)
            begin
                node_tab[n] <= '0;
            end
        end
        else if (ct.node_app)
        begin
            node_tab[ni] <= req_reg.node_address;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ct.load)
        begin
            req_reg <= req;
        end
        if (ct.slot_new)
        begin
            period_tab[si] <= req_reg.interval;
            due_tab[si]    <= req_reg.current_time + req_reg.interval;
            hcnt_tab[si]   <= HW'(1);
        end
        if (ct.slot_join)
        begin
            hcnt_tab[si] <= hcnt_tab[si] + HW'(1);
        end
        if (ct.resched)
        begin
            due_tab[si] <= req_reg.current_time + period_tab[si];
        end
        result_reg <= result_next;
    end

    // result word
    always_comb
    begin
        result_next = '0;
        result_next.last = 1'b1;
        if (ct.emit_node)
        begin
            result_next.result_kind = nris_pkg::KIND_NODE;
            if (st.node_hit)
            begin
                result_next.node_id = 3'(idx_reg);
            end
            else if (st.node_full)
            begin
                result_next.status = 1'b1;
            end
            else
            begin
                result_next.node_id = 3'(nodes_reg);
            end
        end
        else if (ct.emit_add)
        begin
            result_next.result_kind = nris_pkg::KIND_ADDED;
            result_next.status = st.slot_hit ? st.h_full : st.slot_full;
        end
        else if (ct.emit_disp)
        begin
            result_next.result_kind   = nris_pkg::KIND_DISPATCH;
            result_next.fired_handler = rd_data[7:0];
            result_next.dispatch_all  = rd_data[8];
            result_next.node_count    = 4'(nodes_reg);
            result_next.last          = ct.mark_last ||
                (sent_reg == KW'(nris_pkg::MAX_RESULTS - 1));
        end
    end

    assign done = done_reg;
    assign result = result_reg;

    `NRIS_ASSERT(a_nodes_range, nodes_reg != '0 && nodes_reg <= NW'(NODE_SLOTS),
        "node count out of range")
    `NRIS_ASSERT(a_slots_range, slots_reg <= SW'(INTERVAL_SLOTS), "slot count out of range")
    `NRIS_ASSERT_NEXT(a_append_grows, ct.node_app, nodes_reg == $past(nodes_reg) + NW'(1),
        "node append lost")

endmodule

// ===== hdl/nris_ram.sv =====
// generic single write port ram with registered read
module nris_ram
#(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
